// File: rtl/core/pirh_pkg.sv
// Package for the peak interval, rate and HRV core.
// Word types for both channels, status codes and sequencer states.
// No dependencies.
package pirh_pkg;

  localparam int unsigned TIME_BITS   = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned RN_BITS     = 16;
  localparam int unsigned PC_BITS     = 7;
  localparam int unsigned HR_BITS     = 16;
  localparam int unsigned HRV_BITS    = 20;

  localparam logic [PC_BITS-1:0]  PC_MAX  = 7'd127;
  localparam logic [HR_BITS-1:0]  HR_MAX  = 16'hFFFF;
  localparam logic [HRV_BITS-1:0] HRV_MAX = 20'hFFFFF;
  localparam logic [RN_BITS-1:0]  RN_RESET = 16'd6000;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FEW_PEAKS = 2'd1,
    STS_ZERO_SUM  = 2'd2,
    STS_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_STAT,
    ST_RMUL,
    ST_RDIV,
    ST_SSMUL,
    ST_MQMUL,
    ST_DIFF,
    ST_SQRT,
    ST_SDDIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TIME_BITS-1:0]          sample_time;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic                          peak_found;
    logic [TIME_BITS-1:0]          peak_time;
    logic signed [SAMPLE_BITS-1:0] peak_value;
    logic                          frame_done;
    logic [PC_BITS-1:0]            peak_count;
    logic [HR_BITS-1:0]            pulse_rate;
    logic [HRV_BITS-1:0]           hrv_q4;
    logic [1:0]                    status;
  } out_word_t;

endpackage

// File: rtl/core/peak_interval_rate_and_hrv_core.sv
// Peak interval, rate and HRV core: local maximum detection, interval sums,
// frame-end rate division and standard deviation on one shared add/sub unit.
// Depends on pirh_pkg.
//
// Ordinary word: result registered at the accept edge; the next word is taken
// after the ST_UPD state has added the interval and its square to the sums.
// Last word: the shift-add multiplies, two restoring divides and the bit-pair
// square root all run in turn on the one adder; when status is not ok the
// sequencer goes from ST_STAT straight to ST_DONE.
// Reset: frame state cleared, rate_numerator back to 6000, no word pending.
module peak_interval_rate_and_hrv_core #(
  parameter int unsigned MAX_PEAKS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pirh_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pirh_pkg::out_word_t  out_word_o
);
  import pirh_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_PEAKS + 1);
  localparam int unsigned LOG_P  = $clog2(MAX_PEAKS);
  localparam int unsigned SUM_W  = TIME_BITS + LOG_P;
  localparam int unsigned SQ_W   = 2 * TIME_BITS + LOG_P;
  localparam int unsigned MQ_W   = SQ_W + CNT_W;
  localparam int unsigned RAD_W  = MQ_W + 8 + (MQ_W % 2);
  localparam int unsigned RT_W   = RAD_W / 2;
  localparam int unsigned NUM_W  = RN_BITS + CNT_W;
  localparam int unsigned DIV_W  = (RT_W > NUM_W) ? RT_W : NUM_W;
  localparam int unsigned IT_MAX = (DIV_W > SUM_W) ? DIV_W : SUM_W;
  localparam int unsigned IT_W   = $clog2(IT_MAX + 1);
  localparam int unsigned AW     = MQ_W;
  localparam int unsigned PC_W   = (CNT_W > PC_BITS) ? CNT_W : PC_BITS;
  localparam int unsigned HW     = (DIV_W > HRV_BITS) ? DIV_W : HRV_BITS;

  // frame state
  state_e                        state_q, state_d;
  logic [RN_BITS-1:0]            rate_num_q;
  logic signed [SAMPLE_BITS-1:0] older_q, older_d;
  logic signed [SAMPLE_BITS-1:0] prev_val_q, prev_val_d;
  logic [TIME_BITS-1:0]          prev_time_q, prev_time_d;
  logic [1:0]                    points_q, points_d;
  logic [CNT_W-1:0]              peaks_q, peaks_d;
  logic [TIME_BITS-1:0]          last_peak_q, last_peak_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic [SQ_W-1:0]               sq_q, sq_d;
  logic                          ovf_q, ovf_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;

  // datapath scratch
  out_word_t            out_q, out_d;
  logic [TIME_BITS-1:0] iv_q, iv_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic [AW-1:0]        mcand_q, mcand_d;
  logic [SUM_W-1:0]     mplier_q, mplier_d;
  logic [AW-1:0]        ss_q, ss_d;
  logic [RAD_W-1:0]     rad_q, rad_d;
  logic [RT_W:0]        r_q, r_d;
  logic [RT_W-1:0]      root_q, root_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [IT_W-1:0]      cnt_q, cnt_d;

  logic                          in_acc;
  logic                          cnt_last;
  logic signed [SAMPLE_BITS-1:0] v_in;
  logic                          is_peak;
  status_e                       sts_c;
  logic [CNT_W-1:0]              m_c;
  logic [2*TIME_BITS-1:0]        iv_sq;

  logic [AW-1:0]        alu_a, alu_b;
  logic                 alu_sub;
  logic [AW:0]          alu_res;
  logic                 alu_ge;
  logic [AW-1:0]        mul_step;
  logic [SUM_W:0]       div_a;
  logic [DIV_W-1:0]     quo_step;
  logic [SUM_W-1:0]     rem_step;
  logic [RT_W+2:0]      sq_a;
  logic [RT_W-1:0]      root_step;
  logic [RT_W:0]        r_step;
  logic [HW-1:0]        quo_ext;
  logic [PC_W-1:0]      pc_ext;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign cnt_last = (cnt_q == IT_W'(1));
  assign v_in     = $signed(in_word_i.sample_value);
  assign is_peak  = (points_q == 2'd2) && (prev_val_q > older_q) && (prev_val_q > v_in);
  assign m_c      = peaks_q - CNT_W'(1);
  assign iv_sq    = {{TIME_BITS{1'b0}}, iv_q} * {{TIME_BITS{1'b0}}, iv_q};
  assign pc_ext   = PC_W'(peaks_q);

  always_comb begin
    if (peaks_q < CNT_W'(2)) begin
      sts_c = STS_FEW_PEAKS;
    end else if (ovf_q) begin
      sts_c = STS_OVERFLOW;
    end else if (sum_q == '0) begin
      sts_c = STS_ZERO_SUM;
    end else begin
      sts_c = STS_OK;
    end
  end

  // shared add/subtract unit
  always_comb begin
    unique case (state_q)
      ST_RMUL, ST_SSMUL, ST_MQMUL: begin
        alu_a = acc_q; alu_b = mcand_q; alu_sub = 1'b0;
      end
      ST_RDIV: begin
        alu_a = AW'(div_a); alu_b = AW'(sum_q); alu_sub = 1'b1;
      end
      ST_SDDIV: begin
        alu_a = AW'(div_a); alu_b = AW'(m_c); alu_sub = 1'b1;
      end
      ST_DIFF: begin
        alu_a = acc_q; alu_b = ss_q; alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a = AW'(sq_a); alu_b = AW'({root_q, 2'b01}); alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0; alu_b = '0; alu_sub = 1'b0;
      end
    endcase
    alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    alu_ge  = !alu_res[AW];
  end

  // one step of each iteration, all off the same adder result
  assign mul_step  = mplier_q[0] ? alu_res[AW-1:0] : acc_q;
  assign div_a     = {rem_q, quo_q[DIV_W-1]};
  assign quo_step  = {quo_q[DIV_W-2:0], alu_ge};
  assign rem_step  = alu_ge ? alu_res[SUM_W-1:0] : div_a[SUM_W-1:0];
  assign sq_a      = {r_q, rad_q[RAD_W-1 -: 2]};
  assign root_step = {root_q[RT_W-2:0], alu_ge};
  assign r_step    = alu_ge ? alu_res[RT_W:0] : sq_a[RT_W:0];
  assign quo_ext   = HW'(quo_step);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_UPD;
      ST_UPD:   state_d = last_q ? ST_STAT : ST_IDLE;
      ST_STAT:  state_d = (sts_c == STS_OK) ? ST_RMUL : ST_DONE;
      ST_RMUL:  if (cnt_last) state_d = ST_RDIV;
      ST_RDIV:  if (cnt_last) state_d = ST_SSMUL;
      ST_SSMUL: if (cnt_last) state_d = ST_MQMUL;
      ST_MQMUL: if (cnt_last) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_SQRT;
      ST_SQRT:  if (cnt_last) state_d = ST_SDDIV;
      ST_SDDIV: if (cnt_last) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    older_d     = older_q;
    prev_val_d  = prev_val_q;
    prev_time_d = prev_time_q;
    points_d    = points_q;
    peaks_d     = peaks_q;
    last_peak_d = last_peak_q;
    sum_d       = sum_q;
    sq_d        = sq_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_d       = out_q;
    iv_d        = iv_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    ss_d        = ss_q;
    rad_d       = rad_q;
    r_d         = r_q;
    root_d      = root_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_d            = '0;
          out_d.frame_done = in_word_i.last;
          iv_d             = '0;
          if (is_peak) begin
            out_d.peak_found = 1'b1;
            out_d.peak_time  = prev_time_q;
            out_d.peak_value = prev_val_q;
            if (peaks_q < CNT_W'(MAX_PEAKS)) begin
              if (peaks_q != '0) begin
                iv_d = prev_time_q - last_peak_q;
              end
              peaks_d     = peaks_q + CNT_W'(1);
              last_peak_d = prev_time_q;
            end else begin
              ovf_d = 1'b1;
            end
          end
          older_d     = prev_val_q;
          prev_val_d  = v_in;
          prev_time_d = in_word_i.sample_time;
          if (points_q != 2'd2) points_d = points_q + 2'd1;
          last_d = in_word_i.last;
          // summary word waits for the sequencer
          if (!in_word_i.last) out_valid_d = 1'b1;
        end
      end
      ST_UPD: begin
        sum_d = sum_q + SUM_W'(iv_q);
        sq_d  = sq_q + SQ_W'(iv_sq);
      end
      ST_STAT: begin
        out_d.status     = sts_c;
        out_d.peak_count = (pc_ext > PC_W'(PC_MAX)) ? PC_MAX : pc_ext[PC_BITS-1:0];
        acc_d    = '0;
        mcand_d  = AW'(rate_num_q);
        mplier_d = SUM_W'(m_c);
        cnt_d    = IT_W'(CNT_W);
      end
      ST_RMUL, ST_SSMUL, ST_MQMUL: begin
        acc_d    = mul_step;
        mcand_d  = {mcand_q[AW-2:0], 1'b0};
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - IT_W'(1);
        if (cnt_last) begin
          if (state_q == ST_RMUL) begin
            quo_d = DIV_W'(mul_step[NUM_W-1:0]);
            rem_d = '0;
            cnt_d = IT_W'(DIV_W);
          end else if (state_q == ST_SSMUL) begin
            ss_d     = mul_step;
            acc_d    = '0;
            mcand_d  = AW'(sq_q);
            mplier_d = SUM_W'(m_c);
            cnt_d    = IT_W'(CNT_W);
          end
        end
      end
      ST_RDIV, ST_SDDIV: begin
        quo_d = quo_step;
        rem_d = rem_step;
        cnt_d = cnt_q - IT_W'(1);
        if (cnt_last) begin
          if (state_q == ST_RDIV) begin
            out_d.pulse_rate = (quo_step > DIV_W'(HR_MAX)) ? HR_MAX : quo_step[HR_BITS-1:0];
            acc_d    = '0;
            mcand_d  = AW'(sum_q);
            mplier_d = sum_q;
            cnt_d    = IT_W'(SUM_W);
          end else begin
            out_d.hrv_q4 = (quo_ext > HW'(HRV_MAX)) ? HRV_MAX : quo_ext[HRV_BITS-1:0];
          end
        end
      end
      ST_DIFF: begin
        // negative variance only after wrapping: clamp to zero
        rad_d  = RAD_W'({(alu_ge ? alu_res[AW-1:0] : {AW{1'b0}}), 8'h00});
        r_d    = '0;
        root_d = '0;
        cnt_d  = IT_W'(RT_W);
      end
      ST_SQRT: begin
        r_d    = r_step;
        root_d = root_step;
        rad_d  = {rad_q[RAD_W-3:0], 2'b00};
        cnt_d  = cnt_q - IT_W'(1);
        if (cnt_last) begin
          quo_d = DIV_W'(root_step);
          rem_d = '0;
          cnt_d = IT_W'(DIV_W);
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        older_d     = '0;
        prev_val_d  = '0;
        prev_time_d = '0;
        points_d    = '0;
        peaks_d     = '0;
        last_peak_d = '0;
        sum_d       = '0;
        sq_d        = '0;
        ovf_d       = 1'b0;
        last_d      = 1'b0;
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_num_q  <= RN_RESET;
      older_q     <= '0;
      prev_val_q  <= '0;
      prev_time_q <= '0;
      points_q    <= '0;
      peaks_q     <= '0;
      last_peak_q <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) rate_num_q <= cfg_wdata_i;
      older_q     <= older_d;
      prev_val_q  <= prev_val_d;
      prev_time_q <= prev_time_d;
      points_q    <= points_d;
      peaks_q     <= peaks_d;
      last_peak_q <= last_peak_d;
      sum_q       <= sum_d;
      sq_q        <= sq_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    iv_q     <= iv_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    ss_q     <= ss_d;
    rad_q    <= rad_d;
    r_q      <= r_d;
    root_q   <= root_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    cnt_q    <= cnt_d;
  end

endmodule

// File: tb/sv/peak_interval_rate_and_hrv_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for peak_interval_rate_and_hrv_core: frames of samples in, one report word out per sample.
// A queue-fed driver and a checking monitor run against an in-bench peak/interval model.
// Depends on pirh_pkg and the core RTL.
module peak_interval_rate_and_hrv_core_tb;
  import pirh_pkg::*;

  localparam int unsigned PEAK_LIMIT  = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_WORDS = 340;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  peak_interval_rate_and_hrv_core #(
    .MAX_PEAKS(PEAK_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  // Frame state of the model
  logic [15:0]        rate_num = RN_RESET;
  logic signed [15:0] f_older = '0;
  logic signed [15:0] f_prev = '0;
  logic [15:0]        f_prev_time = '0;
  int unsigned        f_points = 0;
  int unsigned        f_peaks = 0;
  logic [15:0]        f_last_peak_time = '0;
  logic [63:0]        f_int_sum = '0;
  logic [63:0]        f_int_sq_sum = '0;
  bit                 f_overflow = 1'b0;

  in_word_t    pending_samples[$];
  out_word_t   peak_reports_due[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned in_calm = 0;
  int unsigned stall_left = 0;
  int unsigned out_calm = 0;
  int unsigned samples_queued = 0;
  int unsigned frames_seen = 0;
  int unsigned peaks_seen = 0;
  int unsigned rate_settings = 1;
  int unsigned status_hits[4] = '{default: 0};

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = x;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Advances the frame state by one sample and gives the report it causes
  function automatic out_word_t next_peak_report(input in_word_t w);
    out_word_t          res;
    logic signed [15:0] v;
    logic [15:0]        iv;
    logic [63:0]        m;
    logic [63:0]        rate;
    logic [63:0]        mq;
    logic [63:0]        ss;
    logic [63:0]        diff;
    logic [63:0]        sd;
    status_e            sts;
    res = '0;
    v   = $signed(w.sample_value);
    if (f_points >= 2 && f_prev > f_older && f_prev > v) begin
      res.peak_found = 1'b1;
      res.peak_time  = f_prev_time;
      res.peak_value = f_prev;
      peaks_seen++;
      if (f_peaks < PEAK_LIMIT) begin
        if (f_peaks >= 1) begin
          iv = f_prev_time - f_last_peak_time;   // wraps modulo 2^16
          f_int_sum    = f_int_sum + 64'(iv);
          f_int_sq_sum = f_int_sq_sum + 64'(iv) * 64'(iv);
        end
        f_peaks++;
        f_last_peak_time = f_prev_time;
      end else begin
        f_overflow = 1'b1;
      end
    end
    f_older     = f_prev;
    f_prev      = v;
    f_prev_time = w.sample_time;
    if (f_points < 2) f_points++;

    if (w.last) begin
      res.frame_done = 1'b1;
      res.peak_count = (f_peaks > 127) ? PC_MAX : PC_BITS'(f_peaks);
      if (f_peaks < 2)         sts = STS_FEW_PEAKS;
      else if (f_overflow)     sts = STS_OVERFLOW;
      else if (f_int_sum == 0) sts = STS_ZERO_SUM;
      else                     sts = STS_OK;
      if (sts == STS_OK) begin
        m    = 64'(f_peaks - 1);
        rate = (64'(rate_num) * m) / f_int_sum;
        mq   = m * f_int_sq_sum;
        ss   = f_int_sum * f_int_sum;
        diff = (mq > ss) ? mq - ss : 64'd0;
        sd   = int_sqrt(diff * 64'd256) / m;
        res.pulse_rate = (rate > 64'(HR_MAX)) ? HR_MAX : rate[HR_BITS-1:0];
        res.hrv_q4     = (sd > 64'(HRV_MAX)) ? HRV_MAX : sd[HRV_BITS-1:0];
      end
      res.status = sts;
      status_hits[sts]++;
      frames_seen++;
      f_older = '0; f_prev = '0; f_prev_time = '0; f_points = 0; f_peaks = 0;
      f_last_peak_time = '0; f_int_sum = '0; f_int_sq_sum = '0; f_overflow = 1'b0;
    end
    return res;
  endfunction

  function automatic string fmt_word(input out_word_t w);
    return $sformatf("pf=%0d t=%0d v=%0d fd=%0d n=%0d hr=%0d hrv=%0d st=%0d",
                     w.peak_found, w.peak_time, $signed(w.peak_value), w.frame_done,
                     w.peak_count, w.pulse_rate, w.hrv_q4, w.status);
  endfunction

  task automatic check_word(input out_word_t got);
    out_word_t want;
    string     bad;
    if (peak_reports_due.size() == 0) begin
      if (mismatches < 10) $display("%0t: unexpected word %s", $realtime, fmt_word(got));
      mismatches++;
    end else begin
      want = peak_reports_due.pop_front();
      bad  = "";
      if (got.peak_found !== want.peak_found) bad = {bad, " peak_found"};
      if (got.peak_time  !== want.peak_time)  bad = {bad, " peak_time"};
      if (got.peak_value !== want.peak_value) bad = {bad, " peak_value"};
      if (got.frame_done !== want.frame_done) bad = {bad, " frame_done"};
      if (got.peak_count !== want.peak_count) bad = {bad, " peak_count"};
      if (got.pulse_rate !== want.pulse_rate) bad = {bad, " pulse_rate"};
      if (got.hrv_q4     !== want.hrv_q4)     bad = {bad, " hrv_q4"};
      if (got.status     !== want.status)     bad = {bad, " status"};
      if (bad != "") begin
        if (mismatches < 10) begin
          $display("%0t: mismatch in%s", $realtime, bad);
          $display("  exp %s", fmt_word(want));
          $display("  got %s", fmt_word(got));
        end
        mismatches++;
      end
    end
  endtask

  // Mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 16);
    else             return $urandom_range(30, 150);
  endfunction

  task automatic push_sample(input logic [15:0] t, input logic [15:0] v, input bit lst);
    in_word_t w;
    w.sample_time  = t;
    w.sample_value = v;
    w.last         = lst;
    pending_samples.push_back(w);
    samples_queued++;
  endtask

  task automatic add_frame();
    int unsigned kind;
    int unsigned len;
    int unsigned sel;
    logic [15:0] t;
    logic [15:0] v;
    logic [15:0] pv;
    kind = $urandom_range(0, 99);
    pv   = '0;
    if (kind < 55) begin
      // pulse-like: nondecreasing times (modulo 2^16), alternating high and low with some ties
      len = $urandom_range(3, 32);
      t   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
      for (int unsigned i = 0; i < len; i++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)      v = 16'($urandom);
        else if (sel == 1) v = pv;
        else if (i % 2)    v = 16'($urandom_range(0, 32767));
        else               v = 16'($urandom_range(32768, 65535));
        push_sample(t, v, i == len - 1);
        pv = v;
        if ($urandom_range(0, 7) == 0) t = t;
        else                           t = t + 16'($urandom_range(1, 400));
      end
    end else if (kind < 75) begin
      // narrow amplitudes: plenty of equal neighbours and zero intervals
      len = $urandom_range(1, 20);
      t   = 16'($urandom_range(0, 65535));
      for (int unsigned i = 0; i < len; i++) begin
        v = 16'(int'($urandom_range(0, 4)) - 2);
        push_sample(t, v, i == len - 1);
        t = t + 16'($urandom_range(0, 3));
      end
    end else if (kind < 87) begin
      len = $urandom_range(1, 3);
      for (int unsigned i = 0; i < len; i++)
        push_sample(16'($urandom), 16'($urandom), i == len - 1);
    end else if (kind < 95) begin
      // disordered times
      len = $urandom_range(1, 30);
      for (int unsigned i = 0; i < len; i++)
        push_sample(16'($urandom), 16'($urandom), i == len - 1);
    end else begin
      // strict alternation around the peak limit
      len = $urandom_range(125, 140);
      t   = 16'($urandom_range(0, 1000));
      for (int unsigned i = 0; i < len; i++) begin
        if (i % 2) v = 16'($urandom_range(1, 32767));
        else       v = 16'($urandom_range(32768, 65535));
        push_sample(t, v, i == len - 1);
        t = t + 16'($urandom_range(0, 50));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i || peak_reports_due.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_rate(input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rate_num = val;
    rate_settings++;
    @(negedge clk_i);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Driver: one word per handshake, random gaps after each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      gap_left   <= 0;
      in_calm    <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        in_word_i  <= pending_samples.pop_front();
        in_valid_i <= 1'b1;
        if (in_calm != 0) begin
          gap_left <= 0;
          in_calm  <= in_calm - 1;
        end else if ($urandom_range(0, 49) == 0) begin
          gap_left <= 0;
          in_calm  <= $urandom_range(20, 120);
        end else begin
          gap_left <= pick_gap();
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check outgoing words first, then model the incoming one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      out_calm    <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_word(out_word_o);
      if (in_valid_i && !in_stall_o) peak_reports_due.push_back(next_peak_report(in_word_i));
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;

      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else if (out_calm != 0) begin
        out_stall_i <= 1'b0;
        out_calm    <= out_calm - 1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 59) == 0)     out_calm   <= $urandom_range(20, 150);
        else if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("** peak_interval_rate_and_hrv_core: FAILED **");
    $finish;
  end

  initial begin
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames at the reset rate
    push_sample(16'd0, 16'h8000, 1'b1);                 // single sample frame
    push_sample(16'hFFFF, 16'h7FFF, 1'b0);              // two sample frame
    push_sample(16'hFFFF, 16'h7FFF, 1'b1);
    push_sample(16'd0,   16'h8000, 1'b0);               // three peaks, last one on the final sample
    push_sample(16'd100, 16'h7FFF, 1'b0);
    push_sample(16'd150, 16'h0000, 1'b0);
    push_sample(16'd300, 16'h7FFF, 1'b0);
    push_sample(16'd310, 16'h8000, 1'b0);
    push_sample(16'd400, 16'h7FFF, 1'b0);
    push_sample(16'd401, 16'h7FFE, 1'b1);
    push_sample(16'd5, 16'd0,  1'b0);                   // peaks at one time: zero interval sum
    push_sample(16'd5, 16'd10, 1'b0);
    push_sample(16'd5, 16'd0,  1'b0);
    push_sample(16'd5, 16'd10, 1'b0);
    push_sample(16'd5, 16'd0,  1'b1);
    push_sample(16'd65000, 16'd0,   1'b0);              // time goes backwards: interval wraps
    push_sample(16'd65500, 16'd100, 1'b0);
    push_sample(16'd65500, 16'd0,   1'b0);
    push_sample(16'd10,    16'd100, 1'b0);
    push_sample(16'd10,    16'd0,   1'b1);
    push_sample(16'd0, 16'd0, 1'b0);                    // flat top is no peak
    push_sample(16'd1, 16'd7, 1'b0);
    push_sample(16'd2, 16'd7, 1'b0);
    push_sample(16'd3, 16'd0, 1'b0);
    push_sample(16'd4, 16'd1, 1'b0);
    push_sample(16'd5, 16'd0, 1'b1);
    wait_drained();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       write_rate(16'hFFFF);
        1:       write_rate(16'd1);
        3:       write_rate(RN_RESET);
        default: write_rate(16'($urandom_range(1, 65535)));
      endcase
      if (ph == 0) begin
        // intervals 0 and 1 at full numerator: rate saturates
        push_sample(16'd0,  16'd0, 1'b0);
        push_sample(16'd10, 16'd5, 1'b0);
        push_sample(16'd10, 16'd0, 1'b0);
        push_sample(16'd10, 16'd5, 1'b0);
        push_sample(16'd10, 16'd0, 1'b0);
        push_sample(16'd11, 16'd5, 1'b0);
        push_sample(16'd11, 16'd0, 1'b1);
      end
      while (pending_samples.size() < PHASE_WORDS) add_frame();
      wait_drained();
    end

    repeat (150) @(negedge clk_i);
    if (peak_reports_due.size() != 0) begin
      $display("%0d expected words never arrived", peak_reports_due.size());
      mismatches += peak_reports_due.size();
    end
    $display("Sent %0d samples in %0d frames under %0d rate settings, %0d peaks reported.",
             samples_queued, frames_seen, rate_settings, peaks_seen);
    $display("Frame status: ok %0d, few peaks %0d, zero sum %0d, overflow %0d; %0d mismatches.",
             status_hits[STS_OK], status_hits[STS_FEW_PEAKS], status_hits[STS_ZERO_SUM],
             status_hits[STS_OVERFLOW], mismatches);
    if (mismatches == 0) begin
      $display("** peak_interval_rate_and_hrv_core: PASSED **");
    end else begin
      $display("** peak_interval_rate_and_hrv_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/pirh_pkg.sv
rtl/core/peak_interval_rate_and_hrv_core.sv
tb/sv/peak_interval_rate_and_hrv_core_tb.sv
